// ===== src/hsbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hsbd_pkg
// Shared widths, register codes, result codes and types of the histogram
// shot boundary detector.
// ----------------------------------------------------------------------------
`default_nettype none

package hsbd_pkg;

   localparam int HIST_BINS = 64;
   localparam int POS_W     = $clog2(HIST_BINS + 1);
   localparam int BIN_W     = 24;
   localparam int SUM_W     = 32;
   localparam int IVAL_W    = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   localparam logic [SUM_W-1:0]  LOW_RESET      = SUM_W'(3000);
   localparam logic [SUM_W-1:0]  HIGH_RESET     = SUM_W'(30000);
   localparam logic [IVAL_W-1:0] INTERVAL_RESET = IVAL_W'(10);

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THRESHOLD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_INTERVAL = 2'd2;

   typedef enum logic [1:0] {
      EVENT_NONE = 2'd0,
      EVENT_CUT  = 2'd1,
      EVENT_FADE = 2'd2
   } event_type;

   typedef struct packed {
      logic [BIN_W-1:0] incoming;
      logic [BIN_W-1:0] previous;
      logic [BIN_W-1:0] saved;
   } hist_entry_type;

   typedef struct packed {
      logic shift;       // rotate the ring by one bin
      logic load_bin;    // head entry takes the accepted bin
      logic frame_end;   // commit incoming to previous
      logic take_saved;  // transition opens: saved takes previous
   } cell_ctl_type;

   function automatic logic [BIN_W-1:0] abs_gap(input logic [BIN_W-1:0] a,
                                                input logic [BIN_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

`default_nettype wire

// ===== src/hsbd_req_if.sv =====
// ----------------------------------------------------------------------------
// hsbd_req_if
// Input channel: one histogram bin per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsbd_req_if;
   logic                        valid;
   logic                        ready;
   logic [hsbd_pkg::BIN_W-1:0]  bin_count;
   logic                        last_bin;

   modport source (output valid, output bin_count, output last_bin, input ready);
   modport sink   (input valid, input bin_count, input last_bin, output ready);
endinterface

`default_nettype wire

// ===== src/hsbd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hsbd_rsp_if
// Result channel: one item per frame end, first frame excepted.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsbd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  event_res;
   logic [hsbd_pkg::SUM_W-1:0]  frame_diff;

   modport source (output valid, output event_res, output frame_diff, input ready);
   modport sink   (input valid, input event_res, input frame_diff, output ready);
endinterface

`default_nettype wire

// ===== src/hsbd_cell.sv =====
// ----------------------------------------------------------------------------
// hsbd_cell
// One ring cell: incoming, previous and saved count of one histogram bin.
// Rotates to its neighbor and commits frame-end copies in place.
// ----------------------------------------------------------------------------
`default_nettype none

module hsbd_cell (
   input  logic                     clock,
   input  hsbd_pkg::cell_ctl_type   cell_ctl,
   input  hsbd_pkg::hist_entry_type from_next,
   output hsbd_pkg::hist_entry_type entry
);

   hsbd_pkg::hist_entry_type entry_ff;
   hsbd_pkg::hist_entry_type entry_in;
   hsbd_pkg::hist_entry_type moved;

   always_comb begin
      moved             = cell_ctl.shift ? from_next : entry_ff;
      entry_in.incoming = moved.incoming;
      entry_in.previous = cell_ctl.frame_end ? moved.incoming : moved.previous;
      entry_in.saved    = (cell_ctl.frame_end && cell_ctl.take_saved) ?
                          moved.previous : moved.saved;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// ===== src/hsbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// hsbd_ctrl
// Handshake, saturating difference sums, frame-end decision, frame phase
// and ring realignment after a short frame; registered result item.
// ----------------------------------------------------------------------------
`default_nettype none

module hsbd_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   hsbd_req_if.sink                         req,
   hsbd_rsp_if.source                       rsp,
   input  logic [hsbd_pkg::BIN_W-1:0]       head_previous,
   input  logic [hsbd_pkg::BIN_W-1:0]       head_saved,
   input  logic [hsbd_pkg::SUM_W-1:0]       low_threshold,
   input  logic [hsbd_pkg::SUM_W-1:0]       high_threshold,
   input  logic [hsbd_pkg::IVAL_W-1:0]      check_interval,
   output hsbd_pkg::cell_ctl_type           cell_ctl
);

   localparam logic [hsbd_pkg::POS_W-1:0] POS_FULL = hsbd_pkg::POS_W'(hsbd_pkg::HIST_BINS);

   logic [hsbd_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                         align_ff, align_in;
   logic [hsbd_pkg::SUM_W-1:0]   sum_prev_ff, sum_prev_in;
   logic [hsbd_pkg::SUM_W-1:0]   sum_saved_ff, sum_saved_in;
   logic                         trans_ff, trans_in;
   logic                         seen_ff, seen_in;
   logic [hsbd_pkg::IVAL_W-1:0]  phase_ff, phase_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   rsp_event_ff, rsp_event_in;
   logic [hsbd_pkg::SUM_W-1:0]   rsp_diff_ff, rsp_diff_in;

   logic                         accept;
   logic                         in_range;
   logic [hsbd_pkg::BIN_W-1:0]   gap_prev, gap_saved;
   logic [hsbd_pkg::SUM_W:0]     add_prev, add_saved;
   logic [hsbd_pkg::SUM_W-1:0]   sat_prev, sat_saved;
   logic [hsbd_pkg::POS_W-1:0]   pos_step;
   logic [hsbd_pkg::IVAL_W-1:0]  interval;
   logic [hsbd_pkg::IVAL_W:0]    phase_step;
   logic                         frame_end;
   logic                         is_cut;
   logic                         opening;
   logic [1:0]                   event_code;

   assign req.ready  = !align_ff && (!rsp_valid_ff || rsp.ready);
   assign accept     = req.valid && req.ready;
   assign in_range   = pos_ff < POS_FULL;
   assign frame_end  = accept && req.last_bin;

   always_comb begin
      gap_prev   = in_range ? hsbd_pkg::abs_gap(head_previous, req.bin_count) : '0;
      gap_saved  = in_range ? hsbd_pkg::abs_gap(head_saved, req.bin_count) : '0;
      add_prev   = {1'b0, sum_prev_ff} + {{(hsbd_pkg::SUM_W-hsbd_pkg::BIN_W+1){1'b0}}, gap_prev};
      add_saved  = {1'b0, sum_saved_ff} + {{(hsbd_pkg::SUM_W-hsbd_pkg::BIN_W+1){1'b0}}, gap_saved};
      sat_prev   = add_prev[hsbd_pkg::SUM_W] ? '1 : add_prev[hsbd_pkg::SUM_W-1:0];
      sat_saved  = add_saved[hsbd_pkg::SUM_W] ? '1 : add_saved[hsbd_pkg::SUM_W-1:0];
      pos_step   = in_range ? (pos_ff + 1'b1) : pos_ff;
      interval   = (check_interval == '0) ? hsbd_pkg::IVAL_W'(1) : check_interval;
      phase_step = {1'b0, phase_ff} + 1'b1;
   end

   // frame-end decision
   always_comb begin
      is_cut     = seen_ff && (sat_prev > high_threshold);
      opening    = 1'b0;
      event_code = hsbd_pkg::EVENT_NONE;
      trans_in   = trans_ff;
      if (frame_end && seen_ff) begin
         if (is_cut) begin
            event_code = hsbd_pkg::EVENT_CUT;
            trans_in   = 1'b0;
         end else if (phase_ff == '0) begin
            if (sat_prev > low_threshold) begin
               if (!trans_ff) begin
                  trans_in = 1'b1;
                  opening  = 1'b1;
               end
            end else if (trans_ff) begin
               trans_in = 1'b0;
               if (sat_saved > high_threshold) begin
                  event_code = hsbd_pkg::EVENT_FADE;
               end
            end
         end
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      align_in     = align_ff;
      sum_prev_in  = sum_prev_ff;
      sum_saved_in = sum_saved_ff;
      seen_in      = seen_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_event_in = rsp_event_ff;
      rsp_diff_in  = rsp_diff_ff;

      cell_ctl.shift      = align_ff || (accept && in_range);
      cell_ctl.load_bin   = accept && in_range;
      cell_ctl.frame_end  = frame_end;
      cell_ctl.take_saved = opening;

      if (align_ff) begin
         if (pos_ff + 1'b1 == POS_FULL) begin
            pos_in   = '0;
            align_in = 1'b0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end else if (accept) begin
         if (req.last_bin) begin
            sum_prev_in  = '0;
            sum_saved_in = '0;
            seen_in      = 1'b1;
            phase_in     = (phase_step >= {1'b0, interval}) ? '0 :
                           phase_step[hsbd_pkg::IVAL_W-1:0];
            if (pos_step == POS_FULL) begin
               pos_in = '0;
            end else begin
               pos_in   = pos_step;
               align_in = 1'b1;
            end
            if (seen_ff) begin
               rsp_valid_in = 1'b1;
               rsp_event_in = event_code;
               rsp_diff_in  = sat_prev;
            end
         end else begin
            sum_prev_in  = sat_prev;
            sum_saved_in = sat_saved;
            pos_in       = pos_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         align_ff     <= 1'b0;
         sum_prev_ff  <= '0;
         sum_saved_ff <= '0;
         trans_ff     <= 1'b0;
         seen_ff      <= 1'b0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         align_ff     <= align_in;
         sum_prev_ff  <= sum_prev_in;
         sum_saved_ff <= sum_saved_in;
         trans_ff     <= trans_in;
         seen_ff      <= seen_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_event_ff <= rsp_event_in;
      rsp_diff_ff  <= rsp_diff_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.event_res  = rsp_event_ff;
   assign rsp.frame_diff = rsp_diff_ff;

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_FULL)
      else $error("bin position beyond histogram size");

   a_align_not_home: assert property (@(posedge clock) disable iff (reset)
      align_ff |-> (pos_ff != '0) && !cell_ctl.load_bin)
      else $error("ring realignment while at home position or loading");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (frame_end && seen_ff) |=> rsp_valid_ff && (rsp_diff_ff == $past(sat_prev)))
      else $error("frame end of a later frame gave no result item");

   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      frame_end |=> (sum_prev_ff == '0) && (sum_saved_ff == '0))
      else $error("sums not cleared after frame end");

   a_cut_closes: assert property (@(posedge clock) disable iff (reset)
      (frame_end && is_cut) |=> !trans_ff)
      else $error("abrupt cut left a transition open");

endmodule

`default_nettype wire

// ===== src/histogram_shot_boundary_detector.sv =====
// ----------------------------------------------------------------------------
// histogram_shot_boundary_detector
// Twin-comparison shot boundary detector over per-frame color histograms.
// ----------------------------------------------------------------------------
// Takes one histogram bin per cycle, back to back, also across frame
// boundaries. The stored histograms live in a ring of HIST_BINS cells that
// rotates by one bin per accepted item, so the head cell always holds the
// bin being compared; the frame decision is taken in the cycle the last bin
// is accepted and the result item is presented on the next cycle. After a
// frame with fewer than HIST_BINS bins the ring is rotated home, and the
// input stalls while the ring rotates. The input also holds off while a
// result item waits on a stalled receiver. There is no clearing pass after
// reset. Configuration writes take effect at once and should be issued only
// while the block is idle.
`default_nettype none

module histogram_shot_boundary_detector (
   input  logic                               clock,
   input  logic                               reset,
   hsbd_req_if.sink                           req,
   hsbd_rsp_if.source                         rsp,
   input  logic                               csr_we,
   input  logic [hsbd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hsbd_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   logic [hsbd_pkg::SUM_W-1:0]   low_ff, low_in;
   logic [hsbd_pkg::SUM_W-1:0]   high_ff, high_in;
   logic [hsbd_pkg::IVAL_W-1:0]  interval_ff, interval_in;

   hsbd_pkg::cell_ctl_type       cell_ctl;
   hsbd_pkg::hist_entry_type     ring [hsbd_pkg::HIST_BINS];
   hsbd_pkg::hist_entry_type     head_out;

   always_comb begin
      low_in      = low_ff;
      high_in     = high_ff;
      interval_in = interval_ff;
      if (csr_we) begin
         unique case (csr_index)
            hsbd_pkg::CSR_LOW_THRESHOLD:  low_in      = csr_wdata;
            hsbd_pkg::CSR_HIGH_THRESHOLD: high_in     = csr_wdata;
            hsbd_pkg::CSR_CHECK_INTERVAL: interval_in = csr_wdata[hsbd_pkg::IVAL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff      <= hsbd_pkg::LOW_RESET;
         high_ff     <= hsbd_pkg::HIGH_RESET;
         interval_ff <= hsbd_pkg::INTERVAL_RESET;
      end else begin
         low_ff      <= low_in;
         high_ff     <= high_in;
         interval_ff <= interval_in;
      end
   end

   // head entry wraps to the tail, taking the new bin on the way
   always_comb begin
      head_out = ring[0];
      if (cell_ctl.load_bin) begin
         head_out.incoming = req.bin_count;
      end
   end

   for (genvar k = 0; k < hsbd_pkg::HIST_BINS; k++) begin : g_cell
      if (k == hsbd_pkg::HIST_BINS - 1) begin : g_tail
         hsbd_cell u_cell (
            .clock     (clock),
            .cell_ctl  (cell_ctl),
            .from_next (head_out),
            .entry     (ring[k])
         );
      end else begin : g_body
         hsbd_cell u_cell (
            .clock     (clock),
            .cell_ctl  (cell_ctl),
            .from_next (ring[k+1]),
            .entry     (ring[k])
         );
      end
   end

   hsbd_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req            (req),
      .rsp            (rsp),
      .head_previous  (ring[0].previous),
      .head_saved     (ring[0].saved),
      .low_threshold  (low_ff),
      .high_threshold (high_ff),
      .check_interval (interval_ff),
      .cell_ctl       (cell_ctl)
   );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for histogram_shot_boundary_detector.
// ----------------------------------------------------------------------------
// Feeds per-frame histograms one bin per item and checks every result item
// field by field against a local model of the twin-comparison decision. A
// short table of frames covers the first frame, the bin extremes, cuts,
// extra bins, short frames and one full fade. Random phases follow, each
// with its own thresholds and check interval, mostly steady scenes and
// gradual fades with random content plus cuts, noise and frames of random
// length. Both channels idle and stall at random in some phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int          NUM_DIRECTED  = 21;
   localparam int          NUM_CFGS      = 8;
   localparam int          FRAMES_PER_CFG = 4;
   localparam int          ITEM_TARGET   = 1300;
   localparam int          SETTLE_CYCLES = hsbd_pkg::HIST_BINS + 16;
   localparam int          CYCLE_LIMIT   = 500000;
   localparam int          BIN_MAX       = 24'hFFFFFF;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      hsbd_pkg::event_type        evt;
      logic [hsbd_pkg::SUM_W-1:0] diff;
   } frame_result_type;

   typedef struct {
      int unsigned                nbins;
      logic [hsbd_pkg::BIN_W-1:0] even_val;
      logic [hsbd_pkg::BIN_W-1:0] odd_val;
      bit                         typed;
      frame_result_type           want;
   } frame_row_type;

   typedef struct {
      logic [hsbd_pkg::SUM_W-1:0]  low;
      logic [hsbd_pkg::SUM_W-1:0]  high;
      logic [hsbd_pkg::IVAL_W-1:0] ival;
   } cfg_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [hsbd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [hsbd_pkg::CSR_DAT_W-1:0] csr_wdata;

   hsbd_req_if req_if ();
   hsbd_rsp_if rsp_if ();

   histogram_shot_boundary_detector u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // frame model state
   logic [hsbd_pkg::SUM_W-1:0]  low_thr      = hsbd_pkg::LOW_RESET;
   logic [hsbd_pkg::SUM_W-1:0]  high_thr     = hsbd_pkg::HIGH_RESET;
   logic [hsbd_pkg::IVAL_W-1:0] interval_reg = hsbd_pkg::INTERVAL_RESET;
   logic [hsbd_pkg::BIN_W-1:0]  cur_hist  [hsbd_pkg::HIST_BINS];
   logic [hsbd_pkg::BIN_W-1:0]  prev_hist [hsbd_pkg::HIST_BINS];
   logic [hsbd_pkg::BIN_W-1:0]  keep_hist [hsbd_pkg::HIST_BINS];
   bit                          transition_open = 1'b0;
   bit                          primed          = 1'b0;
   int unsigned                 phase_ctr       = 0;
   int unsigned                 bin_idx         = 0;
   logic [hsbd_pkg::SUM_W-1:0]  diff_prev       = '0;
   logic [hsbd_pkg::SUM_W-1:0]  diff_keep       = '0;

   frame_result_type expected_results [$];
   bit               use_typed = 1'b0;
   frame_result_type typed_result;
   idle_mode_type    idle_mode = IDLE_NONE;
   int unsigned      items_sent = 0;
   int unsigned      mismatch_count = 0;
   int unsigned      cycle_count = 0;

   int               scene      [hsbd_pkg::HIST_BINS];
   int               scene_goal [hsbd_pkg::HIST_BINS];

   frame_row_type directed_frames [NUM_DIRECTED] = '{
      '{64, 24'h000000, 24'h000000, 1'b0, '{hsbd_pkg::EVENT_NONE, 32'h0}},
      '{ 4, 24'h000000, 24'h000000, 1'b1, '{hsbd_pkg::EVENT_NONE, 32'h0}},
      '{ 2, 24'hFFFFFF, 24'hFFFFFF, 1'b1, '{hsbd_pkg::EVENT_CUT,  32'h01FF_FFFE}},
      '{ 2, 24'hFFFFFF, 24'hFFFFFF, 1'b1, '{hsbd_pkg::EVENT_NONE, 32'h0}},
      '{70, 24'h000000, 24'h000000, 1'b1, '{hsbd_pkg::EVENT_CUT,  32'h01FF_FFFE}},
      '{ 1, 24'h000000, 24'h000000, 1'b1, '{hsbd_pkg::EVENT_NONE, 32'h0}},
      '{ 4, 24'd300,    24'd7,      1'b0, '{hsbd_pkg::EVENT_NONE, 32'h0}},
      '{ 4, 24'hABCDEF, 24'h123456, 1'b0, '{hsbd_pkg::EVENT_NONE, 32'h0}},
      '{ 4, 24'h000000, 24'h000000, 1'b0, '{hsbd_pkg::EVENT_NONE, 32'h0}},
      '{ 4, 24'h000000, 24'h000000, 1'b0, '{hsbd_pkg::EVENT_NONE, 32'h0}},
      '{ 4, 24'd4000,   24'h000000, 1'b0, '{hsbd_pkg::EVENT_NONE, 32'h0}},
      '{ 4, 24'd8000,   24'h000000, 1'b0, '{hsbd_pkg::EVENT_NONE, 32'h0}},
      '{ 4, 24'd12000,  24'h000000, 1'b0, '{hsbd_pkg::EVENT_NONE, 32'h0}},
      '{ 4, 24'd16000,  24'h000000, 1'b0, '{hsbd_pkg::EVENT_NONE, 32'h0}},
      '{ 4, 24'd20000,  24'h000000, 1'b0, '{hsbd_pkg::EVENT_NONE, 32'h0}},
      '{ 4, 24'd24000,  24'h000000, 1'b0, '{hsbd_pkg::EVENT_NONE, 32'h0}},
      '{ 4, 24'd28000,  24'h000000, 1'b0, '{hsbd_pkg::EVENT_NONE, 32'h0}},
      '{ 4, 24'd32000,  24'h000000, 1'b0, '{hsbd_pkg::EVENT_NONE, 32'h0}},
      '{ 4, 24'd36000,  24'h000000, 1'b0, '{hsbd_pkg::EVENT_NONE, 32'h0}},
      '{ 4, 24'd40000,  24'h000000, 1'b0, '{hsbd_pkg::EVENT_NONE, 32'h0}},
      '{ 4, 24'd40000,  24'h000000, 1'b1, '{hsbd_pkg::EVENT_FADE, 32'h0}}
   };

   cfg_row_type cfg_table [NUM_CFGS] = '{
      '{32'd3000,       32'd30000,      8'd1},
      '{32'h0,          32'hFFFF_FFFF,  8'd0},
      '{32'hFFFF_FFFF,  32'h0,          8'd2},
      '{32'd2000,       32'd20000,      8'd3},
      '{32'd5000,       32'd60000,      8'd255},
      '{32'd1000,       32'd50000,      8'd1},
      '{32'h0,          32'h0,          8'd2},
      '{32'd3000,       32'd30000,      8'd10}
   };

   function automatic logic [hsbd_pkg::BIN_W-1:0] bin_distance(
      input logic [hsbd_pkg::BIN_W-1:0] a,
      input logic [hsbd_pkg::BIN_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic logic [hsbd_pkg::SUM_W-1:0] saturating_sum(
      input logic [hsbd_pkg::SUM_W-1:0] acc,
      input logic [hsbd_pkg::BIN_W-1:0] term);
      logic [hsbd_pkg::SUM_W:0] wide;
      wide = {1'b0, acc} + (hsbd_pkg::SUM_W+1)'(term);
      return wide[hsbd_pkg::SUM_W] ? {hsbd_pkg::SUM_W{1'b1}} : wide[hsbd_pkg::SUM_W-1:0];
   endfunction

   function automatic logic [hsbd_pkg::BIN_W-1:0] to_bin(input int v);
      if (v < 0) return '0;
      if (v > BIN_MAX) return BIN_MAX[hsbd_pkg::BIN_W-1:0];
      return v[hsbd_pkg::BIN_W-1:0];
   endfunction

   // advances the frame model by one accepted bin; returns 1 when a result is due
   function automatic bit predict_bin(input logic [hsbd_pkg::BIN_W-1:0] bin,
                                      input logic last,
                                      output frame_result_type res);
      int unsigned period;
      bit          produced;
      period   = (interval_reg == 0) ? 1 : interval_reg;
      produced = 1'b0;
      res      = '{hsbd_pkg::EVENT_NONE, '0};
      if (bin_idx < hsbd_pkg::HIST_BINS) begin
         cur_hist[bin_idx] = bin;
         diff_prev = saturating_sum(diff_prev, bin_distance(prev_hist[bin_idx], bin));
         diff_keep = saturating_sum(diff_keep, bin_distance(keep_hist[bin_idx], bin));
         bin_idx++;
      end
      if (!last) return 1'b0;
      if (primed) begin
         if (diff_prev > high_thr) begin
            res.evt = hsbd_pkg::EVENT_CUT;
            transition_open = 1'b0;
         end else if (phase_ctr == 0) begin
            if (diff_prev > low_thr) begin
               if (!transition_open) begin
                  transition_open = 1'b1;
                  keep_hist = prev_hist;
               end
            end else if (transition_open) begin
               transition_open = 1'b0;
               if (diff_keep > high_thr) res.evt = hsbd_pkg::EVENT_FADE;
            end
         end
         res.diff = diff_prev;
         produced = 1'b1;
      end
      for (int k = 0; k < bin_idx; k++) prev_hist[k] = cur_hist[k];
      phase_ctr = (phase_ctr + 1 >= period) ? 0 : phase_ctr + 1;
      primed    = 1'b1;
      bin_idx   = 0;
      diff_prev = '0;
      diff_keep = '0;
      return produced;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic write_csr(input logic [hsbd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [hsbd_pkg::CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         hsbd_pkg::CSR_LOW_THRESHOLD:  low_thr = data;
         hsbd_pkg::CSR_HIGH_THRESHOLD: high_thr = data;
         hsbd_pkg::CSR_CHECK_INTERVAL: interval_reg = data[hsbd_pkg::IVAL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_bin(input logic [hsbd_pkg::BIN_W-1:0] bin, input logic last);
      frame_result_type res;
      int unsigned      gap_pct;
      gap_pct = (idle_mode == IDLE_SENDER) ? 67 : (idle_mode == IDLE_BOTH) ? 20 : 0;
      @(negedge clock);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.bin_count <= bin;
      req_if.last_bin  <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
      if (predict_bin(bin, last, res)) begin
         expected_results.push_back(use_typed ? typed_result : res);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: random stalls, checks at the rising edge
   always @(negedge clock) begin
      int unsigned stall_pct;
      stall_pct = (idle_mode == IDLE_RECEIVER) ? 67 : (idle_mode == IDLE_BOTH) ? 20 : 0;
      rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result item event=%0d diff=%0d",
                                      rsp_if.event_res, rsp_if.frame_diff));
         end else begin
            want = expected_results.pop_front();
            if (rsp_if.event_res !== want.evt)
               report_mismatch($sformatf("event_res got %0d want %0d",
                                         rsp_if.event_res, want.evt));
            if (rsp_if.frame_diff !== want.diff)
               report_mismatch($sformatf("frame_diff got %0d want %0d",
                                         rsp_if.frame_diff, want.diff));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int unsigned len;
      int unsigned fade_left;
      int unsigned cfg_idx;
      bit          noise_frame;
      logic [hsbd_pkg::BIN_W-1:0] bin;

      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.bin_count = '0;
      req_if.last_bin  = 1'b0;
      rsp_if.ready     = 1'b0;
      csr_we           = 1'b0;
      csr_index        = hsbd_pkg::CSR_LOW_THRESHOLD;
      csr_wdata        = '0;
      fade_left        = 0;
      cfg_idx          = 0;
      foreach (scene[k]) begin
         scene[k]      = 0;
         scene_goal[k] = 0;
         cur_hist[k]   = '0;
         prev_hist[k]  = '0;
         keep_hist[k]  = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed frames under reset configuration
      foreach (directed_frames[r]) begin
         use_typed    = directed_frames[r].typed;
         typed_result = directed_frames[r].want;
         for (int k = 0; k < directed_frames[r].nbins; k++)
            send_bin(k[0] ? directed_frames[r].odd_val : directed_frames[r].even_val,
                     k == directed_frames[r].nbins - 1);
      end
      use_typed = 1'b0;

      // random phases
      while (cfg_idx < NUM_CFGS || items_sent < ITEM_TARGET) begin
         wait_drained();
         write_csr(hsbd_pkg::CSR_LOW_THRESHOLD, cfg_table[cfg_idx % NUM_CFGS].low);
         write_csr(hsbd_pkg::CSR_HIGH_THRESHOLD, cfg_table[cfg_idx % NUM_CFGS].high);
         write_csr(hsbd_pkg::CSR_CHECK_INTERVAL,
                   hsbd_pkg::CSR_DAT_W'(cfg_table[cfg_idx % NUM_CFGS].ival));
         idle_mode = idle_mode_type'(cfg_idx % 4);
         repeat (FRAMES_PER_CFG) begin
            if (fade_left == 0) begin
               len = $urandom_range(0, 99);
               if (len < 10) begin
                  foreach (scene[k])
                     scene[k] = $urandom_range(0, 1) ? int'($urandom_range(0, BIN_MAX))
                                                     : int'($urandom_range(0, 100000));
               end else if (len < 40) begin
                  fade_left = $urandom_range(3, 12);
                  foreach (scene_goal[k])
                     scene_goal[k] = to_bin(scene[k] + int'($urandom_range(0, 60000)) - 30000);
               end
            end
            if (fade_left != 0) begin
               foreach (scene[k])
                  scene[k] = scene[k] + (scene_goal[k] - scene[k]) / int'(fade_left);
               fade_left--;
            end
            len = $urandom_range(0, 99);
            len = (len < 55) ? $urandom_range(1, 16) :
                  (len < 90) ? hsbd_pkg::HIST_BINS :
                  $urandom_range(hsbd_pkg::HIST_BINS + 1, hsbd_pkg::HIST_BINS + 8);
            noise_frame = ($urandom_range(0, 99) < 5);
            for (int k = 0; k < len; k++) begin
               bin = noise_frame ? hsbd_pkg::BIN_W'($urandom)
                                 : to_bin(scene[k % hsbd_pkg::HIST_BINS]
                                          + int'($urandom_range(0, 20)));
               send_bin(bin, k == len - 1);
            end
         end
         cfg_idx++;
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/hsbd_pkg.sv
src/hsbd_req_if.sv
src/hsbd_rsp_if.sv
src/hsbd_cell.sv
src/hsbd_ctrl.sv
src/histogram_shot_boundary_detector.sv
test/tb.sv
